FILE: hw/rtl/srsa_pkg.sv
// Shared types, codes and defaults for the sparse row scatter accumulator.
package srsa_pkg;

  localparam int NUM_COLUMNS_DEF = 1024;
  localparam int MAX_PATTERN_DEF = 65536;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    MODE_PLUS  = 2'd0,
    MODE_MINUS = 2'd1,
    MODE_TIMES = 2'd2,
    MODE_DIV   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SAT  = 2'd1,
    ERR_DIVZ = 2'd2,
    ERR_FULL = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MHI,
    ST_MLO,
    ST_DIVLD,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic capture;
    logic mul_hi;
    logic mul_lo;
    logic div_load;
    logic div_step;
    logic clr_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic  in_range;
    logic  claim_now;
    mode_t mode;
    logic  p_zero;
    logic  div_last;
    logic  clr_last;
  } status_t;

endpackage

FILE: hw/rtl/sparse_row_scatter_accumulate.sv
// Top level of the sparse row scatter accumulator.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid/in_ready, in_mode .. in_last  | beat in
//   out     | out_valid/out_ready, out_is_new .. out_done_res | beat out
//
// After reset the marker memory is swept to zero, one entry a cycle, with
// in_ready low. One item at a time: accept, memory read, then commit.
// Claims, plus, minus and out-of-range columns go from the read straight to
// commit; times makes two passes through the shared 32x32 multiplier (high
// half, then low half); divide loads the divider, then takes one quotient
// bit a cycle over 48 bits, skipping the steps if the scaled term is zero.
// The result register lets the next item be accepted while a result waits;
// commit stalls only while that register is still full.
module sparse_row_scatter_accumulate #(
  parameter int NUM_COLUMNS = srsa_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_PATTERN = srsa_pkg::MAX_PATTERN_DEF,
  parameter int VALUE_WIDTH = srsa_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [10:0]        in_column,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_scale,
  input  logic [31:0]        in_mark,
  input  logic               in_first,
  input  logic [16:0]        in_count_in,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_new,
  output logic [15:0]        out_pattern_slot,
  output logic [10:0]        out_pattern_column,
  output logic signed [31:0] out_accum,
  output logic [16:0]        out_count,
  output logic [1:0]         out_error,
  output logic               out_done_res
);

  srsa_pkg::cmd_t    cmd;
  srsa_pkg::status_t st;

  // sequencer: owns state and the output valid
  srsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .cmd(cmd)
  );

  // datapath: marker/accumulator memories, multiplier, divider, count
  srsa_dp #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .MAX_PATTERN(MAX_PATTERN),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_mode(in_mode), .in_column(in_column), .in_value(in_value),
    .in_scale(in_scale), .in_mark(in_mark), .in_first(in_first),
    .in_count_in(in_count_in), .in_last(in_last),
    .out_is_new(out_is_new), .out_pattern_slot(out_pattern_slot),
    .out_pattern_column(out_pattern_column), .out_accum(out_accum),
    .out_count(out_count), .out_error(out_error), .out_done_res(out_done_res)
  );

endmodule

FILE: hw/rtl/srsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/srsa_ctrl.sv
// Sequencer for the sparse row scatter accumulator.
module srsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  srsa_pkg::status_t st,
  output srsa_pkg::cmd_t    cmd
);

  srsa_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srsa_pkg::ST_CLEAR: if (st.clr_last) state_nxt = srsa_pkg::ST_IDLE;
      srsa_pkg::ST_IDLE:  if (in_valid) state_nxt = srsa_pkg::ST_READ;
      srsa_pkg::ST_READ: begin
        if (!st.in_range || st.claim_now) begin
          state_nxt = srsa_pkg::ST_FIN;
        end else begin
          unique case (st.mode)
            srsa_pkg::MODE_TIMES: state_nxt = srsa_pkg::ST_MHI;
            srsa_pkg::MODE_DIV:   state_nxt = srsa_pkg::ST_DIVLD;
            default:              state_nxt = srsa_pkg::ST_FIN;
          endcase
        end
      end
      srsa_pkg::ST_MHI:   state_nxt = srsa_pkg::ST_MLO;
      srsa_pkg::ST_MLO:   state_nxt = srsa_pkg::ST_FIN;
      srsa_pkg::ST_DIVLD: state_nxt = st.p_zero ? srsa_pkg::ST_FIN : srsa_pkg::ST_DIV;
      srsa_pkg::ST_DIV:   if (st.div_last) state_nxt = srsa_pkg::ST_FIN;
      srsa_pkg::ST_FIN:   if (out_free) state_nxt = srsa_pkg::ST_IDLE;
      default:            state_nxt = srsa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      srsa_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      srsa_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      srsa_pkg::ST_READ:  cmd.capture  = 1'b1;
      srsa_pkg::ST_MHI:   cmd.mul_hi   = 1'b1;
      srsa_pkg::ST_MLO:   cmd.mul_lo   = 1'b1;
      srsa_pkg::ST_DIVLD: cmd.div_load = 1'b1;
      srsa_pkg::ST_DIV:   cmd.div_step = 1'b1;
      srsa_pkg::ST_FIN:   cmd.commit   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsa_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == srsa_pkg::ST_READ)
    else $error("accepted beat did not move to read");
  a_rose_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result appeared without commit");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

FILE: hw/rtl/srsa_dp.sv
// Datapath: memories, shared multiplier, divider, result and pattern count.
module srsa_dp #(
  parameter int NUM_COLUMNS = srsa_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_PATTERN = srsa_pkg::MAX_PATTERN_DEF,
  parameter int VALUE_WIDTH = srsa_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srsa_pkg::cmd_t     cmd,
  output srsa_pkg::status_t  st,
  input  logic [1:0]         in_mode,
  input  logic [10:0]        in_column,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_scale,
  input  logic [31:0]        in_mark,
  input  logic               in_first,
  input  logic [16:0]        in_count_in,
  input  logic               in_last,
  output logic               out_is_new,
  output logic [15:0]        out_pattern_slot,
  output logic [10:0]        out_pattern_column,
  output logic signed [31:0] out_accum,
  output logic [16:0]        out_count,
  output logic [1:0]         out_error,
  output logic               out_done_res
);

  localparam int AW       = $clog2(NUM_COLUMNS);
  localparam int CW       = $clog2(MAX_PATTERN + 1);
  localparam int ACC_BITS = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
  localparam int DIV_STEPS = 48;
  localparam int DCW      = $clog2(DIV_STEPS);
  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (ACC_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

  // clamp to accumulator range; top bit flags saturation
  function automatic logic [32:0] sat(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[31:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // signed divide by 2^16, toward zero
  function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 16;
    if (v[65] && (v[15:0] != 16'd0)) begin
      s = s + 66'sd1;
    end
    return s;
  endfunction

  // item registers
  srsa_pkg::mode_t   mode_r;
  logic [10:0]       col_r;
  logic [31:0]       value_r, scale_r, mark_r;
  logic              last_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              in_range_r, claim_r;
  logic signed [31:0] x_r;
  logic [63:0]       p_mag_r, hi_r, lo_r;
  logic              p_neg_r;
  logic [47:0]       qd_r;
  logic [63:0]       rem_r;
  logic [DCW-1:0]    div_cnt_r;
  logic [AW:0]       clr_cnt_r;

  // memories
  logic [31:0] mk_rd, acc_rd;
  logic [31:0] col_m1, in_m1;
  logic [AW-1:0] rd_idx, wr_idx;
  logic mk_we, acc_we;
  logic [AW-1:0] mk_waddr;
  logic [31:0] mk_wdata;
  logic [31:0] acc_wdata;

  assign in_m1  = 32'(in_column) - 32'd1;
  assign col_m1 = 32'(col_r) - 32'd1;
  assign rd_idx = in_m1[AW-1:0];
  assign wr_idx = col_m1[AW-1:0];

  srsa_ram #(.WIDTH(32), .DEPTH(NUM_COLUMNS)) u_marker (
    .clk(clk), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
    .rd_en(cmd.accept), .rd_addr(rd_idx), .rd_data(mk_rd)
  );

  srsa_ram #(.WIDTH(32), .DEPTH(NUM_COLUMNS)) u_accum (
    .clk(clk), .wr_en(acc_we), .wr_addr(wr_idx), .wr_data(acc_wdata),
    .rd_en(cmd.accept), .rd_addr(rd_idx), .rd_data(acc_rd)
  );

  // shared unsigned 32x32 multiplier
  logic [31:0] ax, mul_a, mul_b;
  logic [63:0] product;

  assign ax = x_r[31] ? (~x_r + 32'd1) : x_r;

  always_comb begin
    priority if (cmd.mul_hi) begin
      mul_a = ax;
      mul_b = {1'b0, p_mag_r[62:32]};
    end else if (cmd.mul_lo) begin
      mul_a = ax;
      mul_b = p_mag_r[31:0];
    end else begin
      mul_a = scale_r[31] ? (~scale_r + 32'd1) : scale_r;
      mul_b = value_r[31] ? (~value_r + 32'd1) : value_r;
    end
  end

  assign product = 64'(mul_a) * 64'(mul_b);

  // divider step
  logic [63:0] trial;
  logic        fits;
  assign trial = {rem_r[62:0], qd_r[47]};
  assign fits  = trial >= p_mag_r;

  // result candidates
  logic signed [65:0] p_s, x_s, sum_add, sum_sub, q_times, q_div;
  logic [49:0] t_mag;
  logic        t_neg;
  logic [32:0] r_sel;
  logic [31:0] res;
  logic [1:0]  err;
  logic        full, is_new;

  assign p_s = p_neg_r ? -$signed({2'b00, p_mag_r}) : $signed({2'b00, p_mag_r});
  assign x_s = 66'(x_r) <<< 16;
  assign sum_add = x_s + p_s;
  assign sum_sub = x_s - p_s;
  assign t_mag = (hi_r >= 64'd32768) ? (50'd1 << 40)
                 : (50'(hi_r) << 16) + 50'(lo_r >> 16);
  assign t_neg = x_r[31] != p_neg_r;
  assign q_times = t_neg ? -$signed({16'd0, t_mag}) : $signed({16'd0, t_mag});
  assign q_div = t_neg ? -$signed({18'd0, qd_r}) : $signed({18'd0, qd_r});
  assign full = count_r >= CW'(MAX_PATTERN);

  always_comb begin
    r_sel  = '0;
    err    = srsa_pkg::ERR_NONE;
    is_new = 1'b0;
    if (!in_range_r) begin
      r_sel = '0;
    end else if (claim_r) begin
      r_sel = sat(trunc16(p_s));
      if (full) begin
        err = srsa_pkg::ERR_FULL;
      end else begin
        is_new = 1'b1;
      end
    end else begin
      unique case (mode_r)
        srsa_pkg::MODE_PLUS:  r_sel = sat(trunc16(sum_add));
        srsa_pkg::MODE_MINUS: r_sel = sat(trunc16(sum_sub));
        srsa_pkg::MODE_TIMES: r_sel = sat(q_times);
        default: begin
          if (p_mag_r == 64'd0) begin
            r_sel = '0;
            if (x_r > 32'sd0) begin
              r_sel = {1'b0, SAT_HI[31:0]};
            end else if (x_r < 32'sd0) begin
              r_sel = {1'b0, SAT_LO[31:0]};
            end
          end else begin
            r_sel = sat(q_div);
          end
        end
      endcase
      if (mode_r == srsa_pkg::MODE_DIV && p_mag_r == 64'd0) begin
        err = srsa_pkg::ERR_DIVZ;
      end
    end
    if (in_range_r && !claim_r && r_sel[32]) begin
      err = srsa_pkg::ERR_SAT;
    end else if (in_range_r && claim_r && !full && r_sel[32]) begin
      err = srsa_pkg::ERR_SAT;
    end
  end

  assign res = r_sel[31:0];

  // memory writes: clear sweep or commit
  assign mk_we     = cmd.clr_step || (cmd.commit && in_range_r && claim_r);
  assign mk_waddr  = cmd.clr_step ? clr_cnt_r[AW-1:0] : wr_idx;
  assign mk_wdata  = cmd.clr_step ? 32'd0 : mark_r;
  assign acc_we    = cmd.commit && in_range_r;
  assign acc_wdata = res;

  always_comb begin
    count_nxt = count_r;
    if (cmd.accept && in_first) begin
      count_nxt = (32'(in_count_in) > MAX_PATTERN) ? CW'(MAX_PATTERN) : CW'(in_count_in);
    end else if (cmd.commit && is_new) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      clr_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + (AW+1)'(1);
      end
      if (cmd.div_load) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= srsa_pkg::mode_t'(in_mode);
      col_r   <= in_column;
      value_r <= in_value;
      scale_r <= in_scale;
      mark_r  <= in_mark;
      last_r  <= in_last;
      in_range_r <= (in_column != 11'd0) && (32'(in_column) <= NUM_COLUMNS);
    end
    if (cmd.capture) begin
      x_r     <= acc_rd;
      claim_r <= mk_rd < mark_r;
      p_mag_r <= product;
      p_neg_r <= scale_r[31] != value_r[31];
    end
    if (cmd.mul_hi) hi_r <= product;
    if (cmd.mul_lo) lo_r <= product;
    if (cmd.div_load) begin
      qd_r  <= {ax, 16'd0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= fits ? (trial - p_mag_r) : trial;
      qd_r  <= {qd_r[46:0], fits};
    end
    if (cmd.commit) begin
      out_is_new         <= is_new;
      out_pattern_slot   <= is_new ? 16'(count_r) : 16'd0;
      out_pattern_column <= is_new ? col_r : 11'd0;
      out_accum          <= res;
      out_count          <= 17'(count_nxt);
      out_error          <= err;
      out_done_res       <= last_r;
    end
  end

  assign st.in_range  = in_range_r;
  assign st.claim_now = mk_rd < mark_r;
  assign st.mode      = mode_r;
  assign st.p_zero    = p_mag_r == 64'd0;
  assign st.div_last  = div_cnt_r == DCW'(DIV_STEPS - 1);
  assign st.clr_last  = clr_cnt_r == (AW+1)'(NUM_COLUMNS - 1);

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < p_mag_r)
    else $error("divider remainder out of range");

endmodule
